// ----- rtl/core/tiny_risc_execute_unit_defines.svh -----
// assertion macros for the execute unit
`ifndef TINY_RISC_EXECUTE_UNIT_DEFINES_SVH
`define TINY_RISC_EXECUTE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked at every clock edge outside reset
`define TRE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("execute unit check failed");
// antecedent at one edge, consequent at the next
`define TRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute unit check failed");
`else
`define TRE_ASSERT_ALWAYS(label, prop)
`define TRE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/tre_pkg.sv -----
`default_nettype none

package tre_pkg;

    // register file depth default and instruction field width
    localparam int NUM_REGS_DEF = 16;
    localparam int REG_FIELD_W  = 4;

    // peripheral window, upper bound exclusive
    localparam logic [31:0] PERIPH_LOW  = 32'h3FF0_0000;
    localparam logic [31:0] PERIPH_HIGH = 32'h3FF8_0000;

    // operation codes in the low nibble
    typedef enum logic [3:0] {
        OP_LOAD  = 4'd0,
        OP_STORE = 4'd1,
        OP_ADD   = 4'd2,
        OP_JUMP  = 4'd3,
        OP_NOP   = 4'd4,
        OP_SUB   = 4'd5,
        OP_MOVE  = 4'd6,
        OP_BEQ   = 4'd7
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_ILLEGAL    = 2'd1,
        ST_LOADING    = 2'd2,
        ST_UNEXPECTED = 2'd3
    } status_t;

    // item kinds
    localparam logic FUNC_INSTR  = 1'b0;
    localparam logic FUNC_LDATA  = 1'b1;

    // register file write request
    typedef struct packed {
        logic                   en;
        logic [REG_FIELD_W-1:0] idx;
        logic [31:0]            data;
    } rf_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/tre_regfile.sv -----
`default_nettype none

module tre_regfile #(
    parameter int NUM_REGS = tre_pkg::NUM_REGS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            rd_en,
    input  wire logic [tre_pkg::REG_FIELD_W-1:0] rd_idx_a,
    input  wire logic [tre_pkg::REG_FIELD_W-1:0] rd_idx_b,
    input  wire tre_pkg::rf_wr_t                 wr,
    output logic [31:0]                          rd_data_a,
    output logic [31:0]                          rd_data_b
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int EXT_W = (IDX_W > tre_pkg::REG_FIELD_W) ? IDX_W : tre_pkg::REG_FIELD_W;

    // map an instruction register field onto a memory address
    function automatic logic [IDX_W-1:0] to_addr(input logic [tre_pkg::REG_FIELD_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(idx);
        return ext[IDX_W-1:0];
    endfunction

    function automatic logic in_range(input logic [tre_pkg::REG_FIELD_W-1:0] idx);
        return 32'(idx) < 32'(NUM_REGS);
    endfunction

    logic [31:0]                   rf_reg [NUM_REGS];
    logic [NUM_REGS-1:0]           written_reg;
    logic [31:0]                   q_a_reg;
    logic [31:0]                   q_b_reg;
    logic                          ok_a_reg;
    logic                          ok_b_reg;
    logic [tre_pkg::REG_FIELD_W-1:0] idx_a_reg;
    logic [tre_pkg::REG_FIELD_W-1:0] idx_b_reg;
    logic                          fwd_en_reg;
    logic [tre_pkg::REG_FIELD_W-1:0] fwd_idx_reg;
    logic [31:0]                   fwd_data_reg;

    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic [IDX_W-1:0] addr_w;
    logic             wr_ok;
    logic             ok_a_next;
    logic             ok_b_next;

    assign addr_a = to_addr(rd_idx_a);
    assign addr_b = to_addr(rd_idx_b);
    assign addr_w = to_addr(wr.idx);
    assign wr_ok  = wr.en && in_range(wr.idx);

    // entry counts only once written, otherwise it reads as zero
    assign ok_a_next = in_range(rd_idx_a) ? written_reg[addr_a] : 1'b0;
    assign ok_b_next = in_range(rd_idx_b) ? written_reg[addr_b] : 1'b0;

    // storage array, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            rf_reg[addr_w] <= wr.data;
        end
        if (rd_en)
        begin
            q_a_reg <= rf_reg[addr_a];
            q_b_reg <= rf_reg[addr_b];
        end
    end

    // read side bookkeeping and bypass of the write landing with the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            idx_a_reg    <= rd_idx_a;
            idx_b_reg    <= rd_idx_b;
            fwd_idx_reg  <= wr.idx;
            fwd_data_reg <= wr.data;
        end
    end

    // per-entry written flags and read qualifiers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            ok_a_reg    <= 1'b0;
            ok_b_reg    <= 1'b0;
            fwd_en_reg  <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                written_reg[addr_w] <= 1'b1;
            end
            if (rd_en)
            begin
                ok_a_reg   <= ok_a_next;
                ok_b_reg   <= ok_b_next;
                fwd_en_reg <= wr_ok;
            end
        end
    end

    // resolved operands
    assign rd_data_a = (fwd_en_reg && (fwd_idx_reg == idx_a_reg)) ? fwd_data_reg :
                       (ok_a_reg ? q_a_reg : 32'd0);
    assign rd_data_b = (fwd_en_reg && (fwd_idx_reg == idx_b_reg)) ? fwd_data_reg :
                       (ok_b_reg ? q_b_reg : 32'd0);

endmodule

`default_nettype wire

// ----- rtl/core/tiny_risc_execute_unit.sv -----
// an item passes the execute stage register, then the output register
// throughput: one item per cycle while results are taken, loads and their
// data returns included; set by the single read, modify and write pass
// through the register file, bypassing a write landing with the next read
// reset: asynchronous, registers read as zero, pc zero, no load pending;
// no clearing pass, the block takes items in the first cycle after reset
`default_nettype none

`include "tiny_risc_execute_unit_defines.svh"

module tiny_risc_execute_unit #(
    parameter int NUM_REGS = tre_pkg::NUM_REGS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [31:0] instruction,
    input  wire logic [31:0] load_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      next_pc,
    output logic [1:0]       status,
    output logic             mem_valid,
    output logic             mem_write,
    output logic             mem_peripheral,
    output logic [31:0]      mem_address,
    output logic [31:0]      mem_write_data
);

    // handshake
    logic in_accept;
    logic s1_advance;

    // execute stage
    logic        s1_valid_reg;
    logic        s1_func_reg;
    logic [31:0] s1_instr_reg;
    logic [31:0] s1_ldata_reg;

    // architectural state
    logic [31:0]                     pc_reg;
    logic [31:0]                     pc_next;
    logic                            pending_reg;
    logic                            pending_next;
    logic [tre_pkg::REG_FIELD_W-1:0] target_reg;
    logic [tre_pkg::REG_FIELD_W-1:0] target_next;

    // output register
    logic        out_valid_reg;
    logic [31:0] pc_out_reg;
    logic [1:0]  status_reg;
    logic        mvalid_reg;
    logic        mwrite_reg;
    logic        mperiph_reg;
    logic [31:0] maddr_reg;
    logic [31:0] mdata_reg;

    // register file access
    tre_pkg::op_t                    in_op;
    logic [tre_pkg::REG_FIELD_W-1:0] rd_idx_b;
    logic [31:0]                     opnd_a;
    logic [31:0]                     opnd_b;
    tre_pkg::rf_wr_t                 wr;

    // execute results
    tre_pkg::op_t     op;
    logic [7:0]       imm;
    logic [31:0]      step;
    tre_pkg::status_t status_c;
    logic             mvalid_c;
    logic             mwrite_c;
    logic             mperiph_c;
    logic [31:0]      maddr_c;
    logic [31:0]      mdata_c;

    assign in_accept  = in_valid && in_ready;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // second read port takes t for add and subtract, r otherwise
    assign in_op    = tre_pkg::op_t'(instruction[3:0]);
    assign rd_idx_b = ((in_op == tre_pkg::OP_ADD) || (in_op == tre_pkg::OP_SUB)) ?
                      instruction[7:4] : instruction[11:8];

    tre_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_idx_a  (instruction[15:12]),
        .rd_idx_b  (rd_idx_b),
        .wr        (wr),
        .rd_data_a (opnd_a),
        .rd_data_b (opnd_b)
    );

    // execute stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // execute stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg  <= func;
            s1_instr_reg <= instruction;
            s1_ldata_reg <= load_data;
        end
    end

    assign op   = tre_pkg::op_t'(s1_instr_reg[3:0]);
    assign imm  = s1_instr_reg[11:4];
    assign step = pc_reg + 32'd2;

    // decode and execute one item
    always_comb
    begin
        pc_next      = pc_reg;
        pending_next = pending_reg;
        target_next  = target_reg;
        status_c     = tre_pkg::ST_DONE;
        mvalid_c     = 1'b0;
        mwrite_c     = 1'b0;
        maddr_c      = 32'd0;
        mdata_c      = 32'd0;
        wr.en        = 1'b0;
        wr.idx       = s1_instr_reg[11:8];
        wr.data      = 32'd0;
        priority if (s1_func_reg == tre_pkg::FUNC_LDATA)
        begin
            if (pending_reg)
            begin
                wr.en        = s1_advance;
                wr.idx       = target_reg;
                wr.data      = s1_ldata_reg;
                pending_next = 1'b0;
            end
            else
            begin
                status_c = tre_pkg::ST_UNEXPECTED;
            end
        end
        else if (pending_reg)
        begin
            status_c = tre_pkg::ST_UNEXPECTED;
        end
        else
        begin
            unique case (op)
                tre_pkg::OP_LOAD:
                begin
                    maddr_c      = opnd_a + 32'(imm);
                    mvalid_c     = 1'b1;
                    pending_next = 1'b1;
                    target_next  = s1_instr_reg[11:8];
                    status_c     = tre_pkg::ST_LOADING;
                    pc_next      = step;
                end
                tre_pkg::OP_STORE:
                begin
                    maddr_c  = opnd_a + 32'(imm);
                    mvalid_c = 1'b1;
                    mwrite_c = 1'b1;
                    mdata_c  = opnd_b;
                    pc_next  = step;
                end
                tre_pkg::OP_ADD:
                begin
                    wr.en   = s1_advance;
                    wr.data = opnd_a + opnd_b;
                    pc_next = step;
                end
                tre_pkg::OP_JUMP:
                begin
                    pc_next = opnd_b;
                end
                tre_pkg::OP_NOP:
                begin
                    pc_next = step;
                end
                tre_pkg::OP_SUB:
                begin
                    wr.en   = s1_advance;
                    wr.data = opnd_a - opnd_b;
                    pc_next = step;
                end
                tre_pkg::OP_MOVE:
                begin
                    wr.en   = s1_advance;
                    wr.data = opnd_a;
                    pc_next = step;
                end
                tre_pkg::OP_BEQ:
                begin
                    // signed byte offset in halfwords
                    if (opnd_a == opnd_b)
                    begin
                        pc_next = step + {{23{imm[7]}}, imm, 1'b0};
                    end
                    else
                    begin
                        pc_next = step;
                    end
                end
                default:
                begin
                    status_c = tre_pkg::ST_ILLEGAL;
                end
            endcase
        end
    end

    assign mperiph_c = mvalid_c && (maddr_c >= tre_pkg::PERIPH_LOW) &&
                       (maddr_c < tre_pkg::PERIPH_HIGH);

    // architectural state commits with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= 32'd0;
            pending_reg <= 1'b0;
            target_reg  <= '0;
        end
        else if (s1_advance)
        begin
            pc_reg      <= pc_next;
            pending_reg <= pending_next;
            target_reg  <= target_next;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            pc_out_reg  <= pc_next;
            status_reg  <= status_c;
            mvalid_reg  <= mvalid_c;
            mwrite_reg  <= mwrite_c;
            mperiph_reg <= mperiph_c;
            maddr_reg   <= maddr_c;
            mdata_reg   <= mdata_c;
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_pc        = pc_out_reg;
    assign status         = status_reg;
    assign mem_valid      = mvalid_reg;
    assign mem_write      = mwrite_reg;
    assign mem_peripheral = mperiph_reg;
    assign mem_address    = maddr_reg;
    assign mem_write_data = mdata_reg;

    // checks
    `TRE_ASSERT_NEXT(a_load_sets_pending,
        s1_advance && (status_c == tre_pkg::ST_LOADING), pending_reg)
    `TRE_ASSERT_ALWAYS(a_write_on_commit, wr.en |-> s1_advance)
    `TRE_ASSERT_ALWAYS(a_pending_blocks_instr,
        (pending_reg && s1_valid_reg && !s1_func_reg) |->
        (!wr.en && (status_c == tre_pkg::ST_UNEXPECTED)))
    `TRE_ASSERT_ALWAYS(a_idle_bus_quiet,
        (out_valid && !mem_valid) |-> ((mem_address == 32'd0) &&
        (mem_write_data == 32'd0) && !mem_peripheral && !mem_write))

endmodule

`default_nettype wire

// ----- bench/tb_tiny_risc_execute_unit.sv -----
module tb_tiny_risc_execute_unit;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int ITEMS_PER_PHASE  = 475;
    localparam int RESET_CYCLES     = 11;
    localparam int DRAIN_CYCLES     = 8;

    // opcodes past the defined set
    localparam logic [3:0] FIRST_ILLEGAL_OP = 4'd8;
    localparam logic [3:0] LAST_ILLEGAL_OP  = 4'd15;

    // one retired item as seen on the result channel
    typedef struct {
        logic [31:0]      next_pc;
        tre_pkg::status_t status;
        logic             mem_valid;
        logic             mem_write;
        logic             mem_peripheral;
        logic [31:0]      mem_address;
        logic [31:0]      mem_write_data;
    } retire_t;

    // architectural state tracker and queue of predicted retirements
    class retire_checker;
        logic [31:0] regs [tre_pkg::NUM_REGS_DEF];
        logic [31:0] pc;
        logic        load_pending;
        logic [3:0]  load_target;
        retire_t     pending_retires [$];
        int          errors;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            pc           = '0;
            load_pending = 1'b0;
            load_target  = '0;
            errors       = 0;
        endfunction

        // execute one item against the tracked state
        function retire_t execute_item(logic kind, logic [31:0] word, logic [31:0] ldata);
            retire_t     res;
            logic [7:0]  imm;
            logic [3:0]  rt;
            logic [3:0]  rr;
            logic [3:0]  rs;
            logic [31:0] step;
            res.status         = tre_pkg::ST_DONE;
            res.mem_valid      = 1'b0;
            res.mem_write      = 1'b0;
            res.mem_address    = '0;
            res.mem_write_data = '0;
            imm  = word[11:4];
            rt   = word[7:4];
            rr   = word[11:8];
            rs   = word[15:12];
            step = pc + 32'd2;
            if (kind == tre_pkg::FUNC_LDATA)
            begin
                if (load_pending)
                begin
                    regs[load_target] = ldata;
                    load_pending      = 1'b0;
                end
                else
                    res.status = tre_pkg::ST_UNEXPECTED;
            end
            else if (load_pending)
                res.status = tre_pkg::ST_UNEXPECTED;
            else
            begin
                case (word[3:0])
                    tre_pkg::OP_LOAD:
                    begin
                        res.mem_address = regs[rs] + {24'd0, imm};
                        res.mem_valid   = 1'b1;
                        res.status      = tre_pkg::ST_LOADING;
                        load_pending    = 1'b1;
                        load_target     = rr;
                        pc              = step;
                    end
                    tre_pkg::OP_STORE:
                    begin
                        res.mem_address    = regs[rs] + {24'd0, imm};
                        res.mem_valid      = 1'b1;
                        res.mem_write      = 1'b1;
                        res.mem_write_data = regs[rr];
                        pc                 = step;
                    end
                    tre_pkg::OP_ADD:
                    begin
                        regs[rr] = regs[rs] + regs[rt];
                        pc       = step;
                    end
                    tre_pkg::OP_JUMP:
                        pc = regs[rr];
                    tre_pkg::OP_NOP:
                        pc = step;
                    tre_pkg::OP_SUB:
                    begin
                        regs[rr] = regs[rs] - regs[rt];
                        pc       = step;
                    end
                    tre_pkg::OP_MOVE:
                    begin
                        regs[rr] = regs[rs];
                        pc       = step;
                    end
                    tre_pkg::OP_BEQ:
                    begin
                        // signed byte offset in half-words
                        if (regs[rr] == regs[rs])
                            step = step + {{23{imm[7]}}, imm, 1'b0};
                        pc = step;
                    end
                    default:
                        res.status = tre_pkg::ST_ILLEGAL;
                endcase
            end
            res.next_pc        = pc;
            res.mem_peripheral = res.mem_valid && (res.mem_address >= tre_pkg::PERIPH_LOW)
                                 && (res.mem_address < tre_pkg::PERIPH_HIGH);
            return res;
        endfunction

        function void take_item(logic kind, logic [31:0] word, logic [31:0] ldata);
            pending_retires.push_back(execute_item(kind, word, ldata));
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, actual %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_retire(retire_t got);
            retire_t want;
            if (pending_retires.size() == 0)
            begin
                $error("result with no item outstanding: next_pc %h status %0d",
                       got.next_pc, got.status);
                errors++;
                return;
            end
            want = pending_retires.pop_front();
            check_field("next_pc", want.next_pc, got.next_pc);
            check_field("status", {30'd0, want.status}, {30'd0, got.status});
            check_field("mem_valid", {31'd0, want.mem_valid}, {31'd0, got.mem_valid});
            check_field("mem_write", {31'd0, want.mem_write}, {31'd0, got.mem_write});
            check_field("mem_peripheral", {31'd0, want.mem_peripheral},
                        {31'd0, got.mem_peripheral});
            check_field("mem_address", want.mem_address, got.mem_address);
            check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    wire logic   in_ready;
    logic        func = 1'b0;
    logic [31:0] instruction = '0;
    logic [31:0] load_data = '0;
    wire logic   out_valid;
    logic        out_ready = 1'b0;
    wire logic [31:0] next_pc;
    wire logic [1:0]  status;
    wire logic        mem_valid;
    wire logic        mem_write;
    wire logic        mem_peripheral;
    wire logic [31:0] mem_address;
    wire logic [31:0] mem_write_data;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    retire_checker tracker;

    tiny_risc_execute_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .instruction    (instruction),
        .load_data      (load_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_pc        (next_pc),
        .status         (status),
        .mem_valid      (mem_valid),
        .mem_write      (mem_write),
        .mem_peripheral (mem_peripheral),
        .mem_address    (mem_address),
        .mem_write_data (mem_write_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_retire('{next_pc, tre_pkg::status_t'(status), mem_valid,
                                   mem_write, mem_peripheral, mem_address,
                                   mem_write_data});
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one item, leaving valid high once it has gone
    task automatic send_item(input logic kind, input logic [31:0] word,
                             input logic [31:0] ldata);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= kind;
        instruction <= word;
        load_data   <= ldata;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_item(kind, word, ldata);
    endtask

    task automatic send_instr(input logic [31:0] word);
        send_item(tre_pkg::FUNC_INSTR, word, $urandom);
    endtask

    task automatic send_ldata(input logic [31:0] ldata);
        send_item(tre_pkg::FUNC_LDATA, $urandom, ldata);
    endtask

    // hold off until every predicted result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_retires.size() != 0)
            @(posedge clk);
    endtask

    // word layout: s in 15..12, r in 11..8, t in 7..4; upper half is noise
    function automatic logic [31:0] encode(logic [3:0] op, logic [3:0] rs, logic [3:0] rr,
                                           logic [3:0] rt);
        logic [15:0] noise;
        noise = 16'($urandom);
        return {noise, rs, rr, rt, op};
    endfunction

    // data values biased towards the peripheral window edges and wrap points
    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return tre_pkg::PERIPH_LOW - 32'h100 + $urandom_range(0, 32'h1FF);
            3: return tre_pkg::PERIPH_HIGH - 32'h100 + $urandom_range(0, 32'h1FF);
            4: return $urandom_range(0, 32'h1FF);
            default: return 32'hFFFF_FF00 | $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [3:0] op;
        logic [3:0] rs;
        logic [3:0] rr;
        logic [3:0] rt;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            op = tre_pkg::OP_LOAD;
        else if (pick < 34)
            op = tre_pkg::OP_STORE;
        else if (pick < 46)
            op = tre_pkg::OP_ADD;
        else if (pick < 56)
            op = tre_pkg::OP_SUB;
        else if (pick < 64)
            op = tre_pkg::OP_MOVE;
        else if (pick < 80)
            op = tre_pkg::OP_BEQ;
        else if (pick < 85)
            op = tre_pkg::OP_JUMP;
        else if (pick < 91)
            op = tre_pkg::OP_NOP;
        else
            op = 4'($urandom_range(FIRST_ILLEGAL_OP, LAST_ILLEGAL_OP));
        rs = 4'($urandom);
        rr = 4'($urandom);
        rt = 4'($urandom);
        // same register on both sides so a branch is taken often enough
        if (op == tre_pkg::OP_BEQ && $urandom_range(0, 3) == 0)
            rs = rr;
        return encode(op, rs, rr, rt);
    endfunction

    // random instructions, most loads followed by their data return, stray items now and then
    task automatic run_random(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if (tracker.load_pending)
            begin
                if ($urandom_range(0, 99) < 90)
                    send_ldata(random_value());
                else
                    send_instr(random_instruction());
            end
            else if ($urandom_range(0, 99) < 5)
                send_ldata(random_value());
            else
                send_instr(random_instruction());
            sent++;
        end
    endtask

    initial
    begin : stimulus
        int sender_pct [4];
        int receiver_pct [4];
        sender_pct   = '{0, 46, 0, 16};
        receiver_pct = '{0, 0, 46, 16};
        tracker = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: nop from reset, stray data return
        send_instr(encode(tre_pkg::OP_NOP, 4'h0, 4'h0, 4'h0));
        send_ldata(32'h1234_5678);
        // loads filling registers with window edges and all ones
        send_instr(encode(tre_pkg::OP_LOAD, 4'h0, 4'h1, 4'hF));
        send_ldata(tre_pkg::PERIPH_LOW);
        send_instr(encode(tre_pkg::OP_LOAD, 4'h0, 4'hF, 4'hF));
        // instruction while the load is outstanding is dropped
        send_instr(encode(tre_pkg::OP_ADD, 4'h1, 4'h2, 4'h1));
        send_ldata(32'hFFFF_FFFF);
        send_instr(encode(tre_pkg::OP_LOAD, 4'h0, 4'h3, 4'h0));
        send_ldata(tre_pkg::PERIPH_HIGH - 32'h100);
        send_instr(encode(tre_pkg::OP_LOAD, 4'h0, 4'h5, 4'h0));
        send_ldata(tre_pkg::PERIPH_LOW - 32'd1);
        send_instr(encode(tre_pkg::OP_LOAD, 4'h0, 4'h4, 4'h0));
        send_ldata(tre_pkg::PERIPH_HIGH);
        // stores around the window bounds and an address wrap
        send_instr(encode(tre_pkg::OP_STORE, 4'h1, 4'h1, 4'h0));
        send_instr(encode(tre_pkg::OP_STORE, 4'h3, 4'hF, 4'hF));
        send_instr(encode(tre_pkg::OP_STORE, 4'h5, 4'h0, 4'h0));
        send_instr(encode(tre_pkg::OP_STORE, 4'h4, 4'h0, 4'h0));
        send_instr(encode(tre_pkg::OP_STORE, 4'hF, 4'h0, 4'h1));
        // arithmetic with wrap
        send_instr(encode(tre_pkg::OP_ADD, 4'hF, 4'h6, 4'hF));
        send_instr(encode(tre_pkg::OP_SUB, 4'h0, 4'h7, 4'hF));
        send_instr(encode(tre_pkg::OP_MOVE, 4'h1, 4'h8, 4'h0));
        // branches: most negative taken, most positive taken, not taken
        send_instr(encode(tre_pkg::OP_BEQ, 4'h1, 4'h8, 4'h0));
        send_instr(encode(tre_pkg::OP_BEQ, 4'h7, 4'h7, 4'hF));
        send_instr(encode(tre_pkg::OP_BEQ, 4'h0, 4'h1, 4'h5));
        // jump to all ones then wrap past zero
        send_instr(encode(tre_pkg::OP_JUMP, 4'h0, 4'hF, 4'h0));
        send_instr(encode(tre_pkg::OP_NOP, 4'h0, 4'h0, 4'h0));
        send_instr(encode(FIRST_ILLEGAL_OP, 4'hA, 4'h5, 4'hC));
        send_instr(encode(LAST_ILLEGAL_OP, 4'h3, 4'hC, 4'h6));

        // random phases with different idling on each side
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            sender_idle_pct    = sender_pct[phase];
            receiver_stall_pct = receiver_pct[phase];
            run_random(ITEMS_PER_PHASE);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
